FILE: hdl/ptpd_pkg.sv
`timescale 1ns / 1ps

package ptpd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    // Exact four-term sum of floored products plus the translation element
    localparam int ACC_W     = 67 - FRAC_BITS;
    // Dividend after the fraction shift
    localparam int NUM_W     = ACC_W + FRAC_BITS;
    localparam int QUO_W     = 32;
    // Sign/magnitude, range check, one stage per quotient bit, sign and clamp
    localparam int DIV_LAT   = QUO_W + 3;
    localparam int DOT_LAT   = 2;
    localparam int ELEM_N    = 16;
    localparam int IDX_W     = 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_XFRM = 1'b1;

    localparam logic signed [DATA_W-1:0] ONE_FIX  = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] ZERO_FIX = '0;
    localparam logic signed [DATA_W-1:0] SAT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // Control travelling beside the divider lanes
    typedef struct packed {
        logic valid;
        logic w_zero;
    } ctl_t;

endpackage

FILE: hdl/point_transform_perspective_divide.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while the skid stage is empty; a load word updates the matrix at once.
// The rate is set by the four column lanes (multiply, sum) and the three
// one-bit-per-stage divider pipelines. Reset (aresetn low, synchronous) empties
// the pipeline and output stages and loads the identity matrix.
module point_transform_perspective_divide
    import ptpd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  logic [IDX_W-1:0] s_elem_index,
    input  fix_t             s_elem_value,
    input  fix_t             s_px,
    input  fix_t             s_py,
    input  fix_t             s_pz,
    output logic             m_valid,
    input  logic             m_ready,
    output fix_t             m_ox,
    output fix_t             m_oy,
    output fix_t             m_oz,
    output logic             m_w_zero,
    output logic             m_overflow
);

    fix_t mat_reg [0:ELEM_N-1];
    logic advance, accept;
    logic v1_reg, v2_reg;
    ctl_t ctl_reg [0:DIV_LAT-1];
    acc_t acc [0:3];
    fix_t quo [0:2];
    logic sat [0:2];

    fix_t res_x, res_y, res_z;
    logic res_ovf, res_wz, pipe_fire;

    fix_t ox_reg, oy_reg, oz_reg, sx_reg, sy_reg, sz_reg;
    logic wz_reg, ovf_reg, swz_reg, sovf_reg;
    logic m_valid_reg, skid_valid_reg;

    assign advance = !skid_valid_reg;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;

    // Hold the matrix; load one element per load word
    always_ff @(posedge aclk) begin
        for (int k = 0; k < ELEM_N; k++) begin
            if (!aresetn) begin
                mat_reg[k] <= (k % 5 == 0) ? ONE_FIX : ZERO_FIX;
            end else if (accept && s_cmd == CMD_LOAD && s_elem_index == IDX_W'(k)) begin
                mat_reg[k] <= s_elem_value;
            end
        end
    end

    // One lane per output column
    for (genvar j = 0; j < 4; j++) begin : g_lane
        ptpd_dot u_dot (
            .aclk (aclk),
            .en   (advance),
            .px   (s_px),
            .py   (s_py),
            .pz   (s_pz),
            .m0   (mat_reg[j]),
            .m1   (mat_reg[4 + j]),
            .m2   (mat_reg[8 + j]),
            .m3   (mat_reg[12 + j]),
            .acc  (acc[j])
        );
    end

    for (genvar j = 0; j < 3; j++) begin : g_div
        ptpd_div u_div (
            .aclk (aclk),
            .en   (advance),
            .num  (acc[j]),
            .den  (acc[3]),
            .quo  (quo[j]),
            .sat  (sat[j])
        );
    end

    // Advance the control line beside the lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                ctl_reg[k] <= '0;
            end
        end else if (advance) begin
            v1_reg           <= s_valid && s_cmd == CMD_XFRM;
            v2_reg           <= v1_reg;
            ctl_reg[0].valid  <= v2_reg;
            ctl_reg[0].w_zero <= acc[3] == '0;
            for (int k = 1; k < DIV_LAT; k++) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // Merge the lanes
    assign res_wz    = ctl_reg[DIV_LAT-1].w_zero;
    assign res_x     = res_wz ? ZERO_FIX : quo[0];
    assign res_y     = res_wz ? ZERO_FIX : quo[1];
    assign res_z     = res_wz ? ZERO_FIX : quo[2];
    assign res_ovf   = !res_wz && (sat[0] || sat[1] || sat[2]);
    assign pipe_fire = advance && ctl_reg[DIV_LAT-1].valid;

    // Output word with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && !m_ready) begin
            if (pipe_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            m_valid_reg    <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= pipe_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_ready) begin
            if (pipe_fire) begin
                sx_reg   <= res_x;
                sy_reg   <= res_y;
                sz_reg   <= res_z;
                swz_reg  <= res_wz;
                sovf_reg <= res_ovf;
            end
        end else if (skid_valid_reg) begin
            ox_reg  <= sx_reg;
            oy_reg  <= sy_reg;
            oz_reg  <= sz_reg;
            wz_reg  <= swz_reg;
            ovf_reg <= sovf_reg;
        end else if (pipe_fire) begin
            ox_reg  <= res_x;
            oy_reg  <= res_y;
            oz_reg  <= res_z;
            wz_reg  <= res_wz;
            ovf_reg <= res_ovf;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_ox       = ox_reg;
    assign m_oy       = oy_reg;
    assign m_oz       = oz_reg;
    assign m_w_zero   = wz_reg;
    assign m_overflow = ovf_reg;

endmodule

FILE: hdl/ptpd_dot.sv
`timescale 1ns / 1ps

module ptpd_dot
    import ptpd_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  fix_t px,
    input  fix_t py,
    input  fix_t pz,
    input  fix_t m0,
    input  fix_t m1,
    input  fix_t m2,
    input  fix_t m3,
    output acc_t acc
);

    logic signed [2*DATA_W-1:0] prod0, prod1, prod2;
    acc_t p0_reg, p1_reg, p2_reg, t_reg, acc_reg;

    assign prod0 = px * m0;
    assign prod1 = py * m1;
    assign prod2 = pz * m2;

    // Register floored products and the translation term
    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg <= ACC_W'(prod0 >>> FRAC_BITS);
            p1_reg <= ACC_W'(prod1 >>> FRAC_BITS);
            p2_reg <= ACC_W'(prod2 >>> FRAC_BITS);
            t_reg  <= ACC_W'(m3);
        end
    end

    // Sum the column
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= p0_reg + p1_reg + p2_reg + t_reg;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: hdl/ptpd_div.sv
`timescale 1ns / 1ps

module ptpd_div
    import ptpd_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  acc_t num,
    input  acc_t den,
    output fix_t quo,
    output logic sat
);

    logic [ACC_W-1:0] an_reg, ad_reg;
    logic             neg0_reg;
    logic [NUM_W-1:0] nfull, hi_ext;

    logic [ACC_W-1:0] rem_reg [0:QUO_W];
    logic [ACC_W-1:0] d_reg   [0:QUO_W];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];
    logic [QUO_W-1:0] lo_reg  [0:QUO_W];
    logic             neg_reg [0:QUO_W];
    logic             big_reg [0:QUO_W];

    fix_t quo_reg;
    logic sat_reg;

    // Split into sign and magnitudes
    always_ff @(posedge aclk) begin
        if (en) begin
            an_reg   <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
            ad_reg   <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
            neg0_reg <= num[ACC_W-1] ^ den[ACC_W-1];
        end
    end

    assign nfull  = {an_reg, {FRAC_BITS{1'b0}}};
    assign hi_ext = nfull >> QUO_W;

    // Flag quotients of 2^32 and above, seed the remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= hi_ext[ACC_W-1:0];
            d_reg[0]   <= ad_reg;
            q_reg[0]   <= '0;
            lo_reg[0]  <= nfull[QUO_W-1:0];
            neg_reg[0] <= neg0_reg;
            big_reg[0] <= hi_ext >= NUM_W'(ad_reg);
        end
    end

    // One restoring step per stage
    for (genvar i = 0; i < QUO_W; i++) begin : g_step
        logic [ACC_W:0] trial;
        logic           fits;

        assign trial = {rem_reg[i], lo_reg[i][QUO_W-1-i]};
        assign fits  = trial >= {1'b0, d_reg[i]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= fits ? ACC_W'(trial - {1'b0, d_reg[i]}) : trial[ACC_W-1:0];
                q_reg[i+1]   <= {q_reg[i][QUO_W-2:0], fits};
                d_reg[i+1]   <= d_reg[i];
                lo_reg[i+1]  <= lo_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                big_reg[i+1] <= big_reg[i];
            end
        end
    end

    // Apply sign and clamp
    always_ff @(posedge aclk) begin
        if (en) begin
            if (neg_reg[QUO_W]) begin
                if (big_reg[QUO_W] || q_reg[QUO_W] > QUO_W'(SAT_MIN)) begin
                    quo_reg <= SAT_MIN;
                    sat_reg <= 1'b1;
                end else begin
                    quo_reg <= fix_t'(-q_reg[QUO_W]);
                    sat_reg <= 1'b0;
                end
            end else begin
                if (big_reg[QUO_W] || q_reg[QUO_W][QUO_W-1]) begin
                    quo_reg <= SAT_MAX;
                    sat_reg <= 1'b1;
                end else begin
                    quo_reg <= fix_t'(q_reg[QUO_W]);
                    sat_reg <= 1'b0;
                end
            end
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

FILE: hdl/ptpd_checker.sv
`timescale 1ns / 1ps

module ptpd_checker
    import ptpd_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input fix_t m_ox,
    input fix_t m_oy,
    input fix_t m_oz,
    input logic m_w_zero,
    input logic m_overflow
);

    // Stalled result word holds its x coordinate and zero-w flag
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ox) && $stable(m_w_zero))
        else $error("result word changed while stalled");

    // Zero w gives zero coordinates
    a_wz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_w_zero |-> m_ox == '0 && m_oy == '0 && m_oz == '0)
        else $error("zero w with nonzero coordinates");

    // Zero w never reports saturation
    a_wz_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_w_zero |-> !m_overflow)
        else $error("overflow with zero w");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word after reset");

endmodule

bind point_transform_perspective_divide ptpd_checker u_ptpd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_ox       (m_ox),
    .m_oy       (m_oy),
    .m_oz       (m_oz),
    .m_w_zero   (m_w_zero),
    .m_overflow (m_overflow)
);

FILE: test/ptpd_checker.sv
`timescale 1ns / 1ps

module ptpd_scoreboard
    import ptpd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             s_cmd,
    input  logic [IDX_W-1:0] s_elem_index,
    input  fix_t             s_elem_value,
    input  fix_t             s_px,
    input  fix_t             s_py,
    input  fix_t             s_pz,
    input  logic             m_valid,
    input  logic             m_ready,
    input  fix_t             m_ox,
    input  fix_t             m_oy,
    input  fix_t             m_oz,
    input  logic             m_w_zero,
    input  logic             m_overflow,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        fix_t ox;
        fix_t oy;
        fix_t oz;
        logic w_zero;
        logic overflow;
    } point_out_t;

    fix_t       mat_shadow [ELEM_N];
    point_out_t point_queue [$];

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        fail_count++;
    endtask

    // Floor division by 2^FRAC_BITS: arithmetic shift floors already
    function automatic longint floor_frac(input longint p);
        return p >>> FRAC_BITS;
    endfunction

    // Quotient (num << FRAC_BITS) / den, truncated toward zero, then clamped
    function automatic longint divide_clamp(input longint num, input longint den,
                                            inout logic sat);
        logic signed [127:0] n, d, q;
        n = num;
        n = n <<< FRAC_BITS;
        d = den;
        q = n / d;
        if (q > 128'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (q < -128'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return longint'(q);
    endfunction

    function automatic point_out_t transform_point(input fix_t x, input fix_t y, input fix_t z);
        point_out_t r;
        longint     acc [4];
        longint     p [3];
        logic       sat;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        sat = 1'b0;
        for (int j = 0; j < 4; j++) begin
            acc[j] = longint'(mat_shadow[12 + j]);
            for (int k = 0; k < 3; k++)
                acc[j] += floor_frac(p[k] * longint'(mat_shadow[k * 4 + j]));
        end
        r.w_zero = 1'b0;
        if (acc[3] == 0) begin
            r.ox = '0;
            r.oy = '0;
            r.oz = '0;
            r.w_zero = 1'b1;
            r.overflow = 1'b0;
            return r;
        end
        r.ox = fix_t'(divide_clamp(acc[0], acc[3], sat));
        r.oy = fix_t'(divide_clamp(acc[1], acc[3], sat));
        r.oz = fix_t'(divide_clamp(acc[2], acc[3], sat));
        r.overflow = sat;
        return r;
    endfunction

    // Track matrix loads, predict transforms, compare result words
    always @(posedge aclk) begin
        point_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < ELEM_N; i++)
                mat_shadow[i] = (i % 5 == 0) ? ONE_FIX : ZERO_FIX;
            point_queue.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (point_queue.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    want = point_queue.pop_front();
                    if (m_ox !== want.ox) report("ox", m_ox, want.ox);
                    if (m_oy !== want.oy) report("oy", m_oy, want.oy);
                    if (m_oz !== want.oz) report("oz", m_oz, want.oz);
                    if (m_w_zero !== want.w_zero) report("w_zero", m_w_zero, want.w_zero);
                    if (m_overflow !== want.overflow)
                        report("overflow", m_overflow, want.overflow);
                end
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_LOAD)
                    mat_shadow[s_elem_index] = s_elem_value;
                else
                    point_queue.push_back(transform_point(s_px, s_py, s_pz));
            end
        end
        pending = point_queue.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import ptpd_pkg::*;

    localparam int LIMIT = 400000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_cmd = CMD_LOAD;
    logic [IDX_W-1:0] s_elem_index = '0;
    fix_t             s_elem_value = '0;
    fix_t             s_px = '0;
    fix_t             s_py = '0;
    fix_t             s_pz = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    fix_t             m_ox, m_oy, m_oz;
    logic             m_w_zero, m_overflow;
    int               fail_count;
    int               pending;
    int               cycle = 0;
    bit               calm = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    point_transform_perspective_divide u_top (.*);

    ptpd_scoreboard u_chk (.*);

    // Stall the result side at random, except in the calm stretch
    always @(posedge aclk)
        m_ready <= calm || ($urandom_range(99) >= 22);

    // Abort on a hung run
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic fix_t edge_val();
        case ($urandom_range(7))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return ZERO_FIX;
            3: return ONE_FIX;
            4: return -ONE_FIX;
            5: return fix_t'($urandom_range(65535)) - 32768;
            default: return fix_t'($urandom());
        endcase
    endfunction

    // Hold one word until accepted, with a random gap ahead of it
    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx, input fix_t val,
                             input fix_t x, input fix_t y, input fix_t z);
        while (!calm && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_elem_index <= idx;
        s_elem_value <= val;
        s_px <= x;
        s_py <= y;
        s_pz <= z;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_load(input logic [IDX_W-1:0] idx, input fix_t val);
        send_word(CMD_LOAD, idx, val, fix_t'($urandom()), fix_t'($urandom()),
                  fix_t'($urandom()));
    endtask

    task automatic send_point(input fix_t x, input fix_t y, input fix_t z);
        send_word(CMD_XFRM, IDX_W'($urandom()), fix_t'($urandom()), x, y, z);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        fix_t v;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identity matrix: extremes pass through
        send_point(ONE_FIX, -ONE_FIX, ZERO_FIX);
        send_point(SAT_MAX, SAT_MIN, SAT_MAX);
        send_point(SAT_MIN, SAT_MIN, SAT_MIN);
        // Zero w
        send_load(IDX_W'(15), ZERO_FIX);
        send_point(ONE_FIX, ONE_FIX, ONE_FIX);
        // Tiny w forces saturation, both signs
        send_load(IDX_W'(15), 32'sd1);
        send_point(SAT_MAX, SAT_MIN, ONE_FIX);
        send_load(IDX_W'(15), -32'sd1);
        send_point(SAT_MAX, SAT_MIN, ZERO_FIX);
        // Quotient of exactly -2^31 is in range
        send_load(IDX_W'(15), ONE_FIX);
        send_load(IDX_W'(12), SAT_MIN);
        send_point(ZERO_FIX, ZERO_FIX, ZERO_FIX);
        send_load(IDX_W'(3), SAT_MAX);
        send_load(IDX_W'(7), SAT_MIN);
        send_point(SAT_MAX, SAT_MAX, SAT_MIN);
        drain();

        // Random phase: mostly points, some loads, small matrices often
        for (int n = 0; n < 500; n++) begin
            if (n == 150) begin
                drain();
                calm = 1'b1;
            end
            if (n == 250) calm = 1'b0;
            if (n == 350) begin
                drain();
                for (int i = 0; i < ELEM_N; i++)
                    send_load(IDX_W'(i), (i % 5 == 0) ? ONE_FIX : ZERO_FIX);
            end
            if ($urandom_range(3) == 0) begin
                v = ($urandom_range(1)) ? edge_val() : fix_t'($urandom_range(262143)) - 131072;
                send_load(IDX_W'($urandom()), v);
            end else begin
                send_point(edge_val(), edge_val(), edge_val());
            end
        end
        drain();
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
